// ===== hw/rtl/ptw_pkg.sv =====
// Page table walker package: field widths, status/page-size/level codes,
// payload structs. No dependencies.
package ptw_pkg;

   localparam int PA_W  = 52;   // physical address field width
   localparam int VA_W  = 48;   // virtual address width
   localparam int PTE_W = 64;   // table entry width
   localparam int IDX_W = 9;    // table index bits per level

   localparam int PHYS_ADDR_BITS_DEFAULT = 52;

   localparam int SHIFT_4K = 12;
   localparam int SHIFT_2M = 21;
   localparam int SHIFT_1G = 30;

   localparam int PTE_PRESENT_BIT = 0;
   localparam int PTE_LARGE_BIT   = 7;

   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_RESP  = 1'b1;

   localparam logic [1:0] STATUS_READ  = 2'd0;
   localparam logic [1:0] STATUS_DONE  = 2'd1;
   localparam logic [1:0] STATUS_FAULT = 2'd2;
   localparam logic [1:0] STATUS_PROTO = 2'd3;

   localparam logic [1:0] PAGE_4K = 2'd0;
   localparam logic [1:0] PAGE_2M = 2'd1;
   localparam logic [1:0] PAGE_1G = 2'd2;

   // level of the entry being awaited
   localparam logic [1:0] LVL_1 = 2'd0;
   localparam logic [1:0] LVL_2 = 2'd1;
   localparam logic [1:0] LVL_3 = 2'd2;
   localparam logic [1:0] LVL_4 = 2'd3;

   typedef struct packed {
      logic              action;
      logic [PA_W-1:0]   root_base;
      logic [VA_W-1:0]   virt_addr;
      logic [PTE_W-1:0]  entry_data;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PA_W-1:0]   read_address;
      logic [PA_W-1:0]   physical_address;
      logic [1:0]        page_span;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/ptw_if.sv =====
// Valid/ready channel interfaces for the page table walker request and
// response transactions. Depends on ptw_pkg.
interface ptw_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [ptw_pkg::PA_W-1:0]    root_base;
   logic [ptw_pkg::VA_W-1:0]    virt_addr;
   logic [ptw_pkg::PTE_W-1:0]   entry_data;

   modport source (output valid, action, root_base, virt_addr, entry_data,
                   input ready);
   modport sink   (input valid, action, root_base, virt_addr, entry_data,
                   output ready);
endinterface

interface ptw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [ptw_pkg::PA_W-1:0]    read_address;
   logic [ptw_pkg::PA_W-1:0]    physical_address;
   logic [1:0]                  page_span;

   modport source (output valid, status, read_address, physical_address, page_span,
                   input ready);
   modport sink   (input valid, status, read_address, physical_address, page_span,
                   output ready);
endinterface

// ===== hw/rtl/ptw_walk_core.sv =====
// Walk state (busy, level, saved virtual address) and the one-level step
// logic that turns a transaction into its result. Depends on ptw_pkg.
module ptw_walk_core #(
   parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  ptw_pkg::req_payload_type   item,
   output ptw_pkg::rsp_payload_type   result
);

   localparam int PaW = ptw_pkg::PA_W;
   localparam logic [PaW-1:0] PhysMask  = {PaW{1'b1}} >> (PaW - PHYS_ADDR_BITS);
   localparam logic [PaW-1:0] FrameMask =
      PhysMask & {{(PaW-ptw_pkg::SHIFT_4K){1'b1}}, {ptw_pkg::SHIFT_4K{1'b0}}};

   logic                       busy_ff, busy_in;
   logic [1:0]                 level_ff, level_in;
   logic [ptw_pkg::VA_W-1:0]   saved_ff, saved_in;

   logic [ptw_pkg::IDX_W-1:0]  start_idx;
   logic [ptw_pkg::IDX_W-1:0]  next_idx;
   logic [1:0]                 next_level;
   logic                       present;
   logic                       ps_bit;
   logic [PaW-1:0]             entry_frame;
   logic [PaW-1:0]             pa_1g;
   logic [PaW-1:0]             pa_2m;
   logic [PaW-1:0]             pa_4k;

   assign start_idx   = item.virt_addr[ptw_pkg::VA_W-1 -: ptw_pkg::IDX_W];
   assign next_level  = level_ff - 2'd1;
   assign present     = item.entry_data[ptw_pkg::PTE_PRESENT_BIT];
   assign ps_bit      = item.entry_data[ptw_pkg::PTE_LARGE_BIT];
   assign entry_frame = item.entry_data[PaW-1:0] & FrameMask;

   // index of the table the next read goes to
   always_comb begin
      case (next_level)
         ptw_pkg::LVL_3: next_idx = saved_ff[38:30];
         ptw_pkg::LVL_2: next_idx = saved_ff[29:21];
         default:        next_idx = saved_ff[20:12];
      endcase
   end

   assign pa_1g = ({item.entry_data[PaW-1:ptw_pkg::SHIFT_1G], {ptw_pkg::SHIFT_1G{1'b0}}}
                   | {{(PaW-ptw_pkg::SHIFT_1G){1'b0}}, saved_ff[ptw_pkg::SHIFT_1G-1:0]})
                  & PhysMask;
   assign pa_2m = ({item.entry_data[PaW-1:ptw_pkg::SHIFT_2M], {ptw_pkg::SHIFT_2M{1'b0}}}
                   | {{(PaW-ptw_pkg::SHIFT_2M){1'b0}}, saved_ff[ptw_pkg::SHIFT_2M-1:0]})
                  & PhysMask;
   assign pa_4k = (entry_frame
                   | {{(PaW-ptw_pkg::SHIFT_4K){1'b0}}, saved_ff[ptw_pkg::SHIFT_4K-1:0]})
                  & PhysMask;

   always_comb begin
      busy_in  = busy_ff;
      level_in = level_ff;
      saved_in = saved_ff;
      result   = '0;
      if (item.action == ptw_pkg::ACTION_START) begin
         if (busy_ff) begin
            result.status = ptw_pkg::STATUS_PROTO;
         end else begin
            busy_in  = 1'b1;
            level_in = ptw_pkg::LVL_4;
            saved_in = item.virt_addr;
            result.status       = ptw_pkg::STATUS_READ;
            result.read_address = (item.root_base & FrameMask)
                                  | {{(PaW-ptw_pkg::SHIFT_4K){1'b0}}, start_idx, 3'b000};
         end
      end else if (!busy_ff) begin
         result.status = ptw_pkg::STATUS_PROTO;
      end else if (!present) begin
         busy_in  = 1'b0;
         level_in = ptw_pkg::LVL_1;
         result.status = ptw_pkg::STATUS_FAULT;
      end else if (level_ff == ptw_pkg::LVL_3 && ps_bit) begin
         busy_in  = 1'b0;
         level_in = ptw_pkg::LVL_1;
         result.status           = ptw_pkg::STATUS_DONE;
         result.physical_address = pa_1g;
         result.page_span        = ptw_pkg::PAGE_1G;
      end else if (level_ff == ptw_pkg::LVL_2 && ps_bit) begin
         busy_in  = 1'b0;
         level_in = ptw_pkg::LVL_1;
         result.status           = ptw_pkg::STATUS_DONE;
         result.physical_address = pa_2m;
         result.page_span        = ptw_pkg::PAGE_2M;
      end else if (level_ff == ptw_pkg::LVL_1) begin
         busy_in  = 1'b0;
         result.status           = ptw_pkg::STATUS_DONE;
         result.physical_address = pa_4k;
         result.page_span        = ptw_pkg::PAGE_4K;
      end else begin
         level_in = next_level;
         result.status       = ptw_pkg::STATUS_READ;
         result.read_address = entry_frame
                               | {{(PaW-ptw_pkg::SHIFT_4K){1'b0}}, next_idx, 3'b000};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= ptw_pkg::LVL_1;
         saved_ff <= '0;
      end else if (fire) begin
         busy_ff  <= busy_in;
         level_ff <= level_in;
         saved_ff <= saved_in;
      end
   end

endmodule

// ===== hw/rtl/four_level_page_table_walker.sv =====
// Four-level page table walker, top level. Each request passes through the
// input register, then the result register. Throughput: one transaction per
// cycle; a stalled response with the input register full drops request ready.
// Synchronous active-high reset clears the walk state (idle, level 1, saved
// address 0) and both pipeline valids. Depends on ptw_pkg, ptw_if, ptw_walk_core.
module four_level_page_table_walker #(
   parameter int PHYS_ADDR_BITS = ptw_pkg::PHYS_ADDR_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   ptw_req_if.sink       req_port,
   ptw_rsp_if.source     rsp_port
);

   // Two register stages: an input register holding the accepted request
   // transaction, and a result register feeding the response channel. The
   // walk step sits between them; state updates when the request moves on.

   logic                       in_vld_ff, in_vld_in;
   ptw_pkg::req_payload_type   in_ff;
   logic                       out_vld_ff, out_vld_in;
   ptw_pkg::rsp_payload_type   out_ff;
   ptw_pkg::rsp_payload_type   step_result;

   logic out_free;   // result register can load this cycle
   logic advance;    // request in the input register moves to the result
   logic req_fire;

   assign out_free = !out_vld_ff || rsp_port.ready;
   assign advance  = in_vld_ff && out_free;
   assign req_port.ready = !in_vld_ff || out_free;
   assign req_fire = req_port.valid && req_port.ready;

   assign in_vld_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_vld_ff);
   assign out_vld_in = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : out_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff.action     <= req_port.action;
         in_ff.root_base  <= req_port.root_base;
         in_ff.virt_addr  <= req_port.virt_addr;
         in_ff.entry_data <= req_port.entry_data;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   ptw_walk_core #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_ff),
      .result (step_result)
   );

   assign rsp_port.valid            = out_vld_ff;
   assign rsp_port.status           = out_ff.status;
   assign rsp_port.read_address     = out_ff.read_address;
   assign rsp_port.physical_address = out_ff.physical_address;
   assign rsp_port.page_span        = out_ff.page_span;

endmodule

// ===== hw/rtl/ptw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_walker.
module ptw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic [ptw_pkg::PA_W-1:0]   rsp_read_address,
   input logic [ptw_pkg::PA_W-1:0]   rsp_physical_address,
   input logic [1:0]                 rsp_page_span
);

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_read_address) && $stable(rsp_physical_address))
      else $error("stalled response transaction changed");

   a_pa_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ptw_pkg::STATUS_DONE
      |-> rsp_physical_address == '0 && rsp_page_span == ptw_pkg::PAGE_4K)
      else $error("translation fields set without completion");

   a_read_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ptw_pkg::STATUS_READ && rsp_read_address[2:0] == 3'b000)
      || (rsp_status != ptw_pkg::STATUS_READ && rsp_read_address == '0))
      else $error("read address misaligned or set without read request");

   a_page_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ptw_pkg::STATUS_DONE |-> rsp_page_span != 2'd3)
      else $error("illegal page size code");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_port.valid),
   .rsp_ready            (rsp_port.ready),
   .rsp_status           (rsp_port.status),
   .rsp_read_address     (rsp_port.read_address),
   .rsp_physical_address (rsp_port.physical_address),
   .rsp_page_span        (rsp_port.page_span)
);

// ===== bench/testbench.sv =====
// Self-checking bench for four_level_page_table_walker: directed walks from a
// stimulus table, then random walks, scored against an in-bench walker or, on
// fixed rows, a typed answer. Depends on ptw_pkg, ptw_if and the walker RTL.
module testbench;
   import ptw_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int PHYS_BITS    = PHYS_ADDR_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_FROM   = 300;    // no idling on either side in this window
   localparam int QUIET_TO     = 500;
   localparam int HOLD_AFTER   = 650;    // accepted transactions before the long hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;     // pipeline is 2 deep, give it some slack
   localparam int CYCLE_LIMIT  = 300000;
   localparam int REPORT_MAX   = 10;

   localparam logic [63:0] PHYS_MASK  = (64'd1 << PHYS_BITS) - 64'd1;
   localparam logic [63:0] FRAME_MASK = PHYS_MASK & ~64'hFFF;

   // One row of the directed table. word is the root base on a start and the
   // table entry on a response; va only matters on a start.
   typedef struct {
      logic              action;
      logic [63:0]       word;
      logic [VA_W-1:0]   va;
      bit                is_fixed;
      rsp_payload_type   fixed_rsp;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 24;

   // Rows with is_fixed set carry the answer typed in; the rest go to the
   // predictor. Walk levels are noted as the entry being returned.
   stim_row_type directed_table [0:DIRECTED_ROWS-1] = '{
      // response with no walk open
      '{ACTION_RESP,  64'hFFFF_FFFF_FFFF_FFFF, 48'h0,             1'b1,
         '{STATUS_PROTO, 52'h0, 52'h0, PAGE_4K}},
      // all-ones root and address: top index 0x1FF
      '{ACTION_START, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1,
         '{STATUS_READ, 52'hF_FFFF_FFFF_FFF8, 52'h0, PAGE_4K}},
      // start while busy, walk must survive it
      '{ACTION_START, 64'h0,                   48'h0,             1'b1,
         '{STATUS_PROTO, 52'h0, 52'h0, PAGE_4K}},
      '{ACTION_RESP,  64'hFFFF_FFFF_FFFF_FF7F, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L4
      '{ACTION_RESP,  64'h7FF0_0000_0000_0001, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L3
      '{ACTION_RESP,  64'h000F_FFFF_FFE0_0081, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L2 2M
      '{ACTION_START, 64'h0,                   48'h0,             1'b1,
         '{STATUS_READ, 52'h0, 52'h0, PAGE_4K}},
      // not present at the top level
      '{ACTION_RESP,  64'h0,                   48'h0,             1'b1,
         '{STATUS_FAULT, 52'h0, 52'h0, PAGE_4K}},
      '{ACTION_START, 64'h0001_2345_6789_AFFF, 48'hA5A5_5A5A_C3C3, 1'b0,
         '{2'd0, 52'h0, 52'h0, 2'd0}},
      '{ACTION_RESP,  64'h8000_0000_0000_0081, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L4 PS
      '{ACTION_RESP,  64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L3 1G
      '{ACTION_START, 64'h0,                   48'hFFFF_FFFF_FFFF, 1'b0,
         '{2'd0, 52'h0, 52'h0, 2'd0}},
      '{ACTION_RESP,  64'h1,                   48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L4
      '{ACTION_RESP,  64'h1,                   48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L3
      '{ACTION_RESP,  64'h1,                   48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L2
      '{ACTION_RESP,  64'hFFFF_FFFF_FFFF_FFFF, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L1 4K
      '{ACTION_START, 64'h0,                   48'h0,             1'b1,
         '{STATUS_READ, 52'h0, 52'h0, PAGE_4K}},
      // page-size set but not present: still a fault
      '{ACTION_RESP,  64'h80,                  48'h0,             1'b1,
         '{STATUS_FAULT, 52'h0, 52'h0, PAGE_4K}},
      '{ACTION_START, 64'hFFFF_FFFF_FFFF_FFFF, 48'h0,             1'b1,
         '{STATUS_READ, 52'hF_FFFF_FFFF_F000, 52'h0, PAGE_4K}},
      '{ACTION_RESP,  64'hFFFF_FFFF_FFFF_FF7F, 48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L4
      // every bit set except present, at level 3
      '{ACTION_RESP,  64'hFFFF_FFFF_FFFF_FFFE, 48'h0,             1'b1,
         '{STATUS_FAULT, 52'h0, 52'h0, PAGE_4K}},
      // low 12 root bits ignored
      '{ACTION_START, 64'h0000_0000_0000_0FFF, 48'h0000_0000_0FFF, 1'b1,
         '{STATUS_READ, 52'h0, 52'h0, PAGE_4K}},
      '{ACTION_RESP,  64'h23,                  48'h0, 1'b0, '{2'd0, 52'h0, 52'h0, 2'd0}}, // L4
      '{ACTION_RESP,  64'h0,                   48'h0,             1'b1,
         '{STATUS_FAULT, 52'h0, 52'h0, PAGE_4K}}
   };

   logic clock = 1'b0;
   logic reset;

   ptw_req_if req_ch ();
   ptw_rsp_if rsp_ch ();

   four_level_page_table_walker #(
      .PHYS_ADDR_BITS(PHYS_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: a private copy of the walk state, advanced once per accepted
   // request transaction.
   // ---------------------------------------------------------------------
   bit              walker_busy = 1'b0;
   logic [1:0]      await_level = LVL_1;
   logic [VA_W-1:0] latched_va  = '0;

   rsp_payload_type expected_walk_rsps [$];
   int              error_count   = 0;
   int              reqs_accepted = 0;
   int              items_sent    = 0;
   int              cycle_count   = 0;
   bit              quiet         = 1'b0;

   // Typed expectation for the transaction now on the request channel;
   // updated with the payload so the monitor sees the matching value.
   bit              cur_is_fixed  = 1'b0;
   rsp_payload_type cur_fixed_rsp = '0;

   // Address of the 8-byte entry for the given level inside the table at base.
   function automatic logic [PA_W-1:0] table_entry_addr(logic [63:0] base, logic [1:0] level);
      logic [IDX_W-1:0] idx;
      logic [63:0]      addr;
      idx  = IDX_W'(64'(latched_va) >> (SHIFT_4K + IDX_W * int'(level)));
      addr = ((base & FRAME_MASK) | (64'(idx) << 3)) & PHYS_MASK;
      return addr[PA_W-1:0];
   endfunction

   function automatic rsp_payload_type predict_walk(req_payload_type item);
      rsp_payload_type r;
      logic [63:0]     e;
      logic [63:0]     off;
      logic [63:0]     pa;
      int              shift;
      logic [1:0]      size;
      r = '0;
      if (item.action == ACTION_START) begin
         if (walker_busy) begin
            // start while a walk is open: flagged, walk untouched
            r.status = STATUS_PROTO;
         end else begin
            walker_busy  = 1'b1;
            await_level  = LVL_4;
            latched_va   = item.virt_addr;
            r.status       = STATUS_READ;
            r.read_address = table_entry_addr(64'(item.root_base), LVL_4);
         end
         return r;
      end
      if (!walker_busy) begin
         r.status = STATUS_PROTO;
         return r;
      end
      e = item.entry_data;
      if (!e[PTE_PRESENT_BIT]) begin
         walker_busy = 1'b0;
         await_level = LVL_1;
         r.status    = STATUS_FAULT;
      end else if ((e[PTE_LARGE_BIT] && (await_level == LVL_3 || await_level == LVL_2))
                   || await_level == LVL_1) begin
         // terminal entry: page-size bit only counts at levels 3 and 2
         if (e[PTE_LARGE_BIT] && await_level == LVL_3) begin
            shift = SHIFT_1G;
            size  = PAGE_1G;
         end else if (e[PTE_LARGE_BIT] && await_level == LVL_2) begin
            shift = SHIFT_2M;
            size  = PAGE_2M;
         end else begin
            shift = SHIFT_4K;
            size  = PAGE_4K;
         end
         off = (64'd1 << shift) - 64'd1;
         pa  = ((e & PHYS_MASK & ~off) | (64'(latched_va) & off)) & PHYS_MASK;
         walker_busy        = 1'b0;
         await_level        = LVL_1;
         r.status           = STATUS_DONE;
         r.physical_address = pa[PA_W-1:0];
         r.page_span        = size;
      end else begin
         await_level    = await_level - 2'd1;
         r.status       = STATUS_READ;
         r.read_address = table_entry_addr(e, await_level);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard
   // ---------------------------------------------------------------------
   task automatic check_rsp(rsp_payload_type seen);
      rsp_payload_type want;
      if (expected_walk_rsps.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("[%0t] unexpected response: status=%0d rd=%h pa=%h size=%0d", $realtime,
                     seen.status, seen.read_address, seen.physical_address, seen.page_span);
         return;
      end
      want = expected_walk_rsps.pop_front();
      if (seen.status !== want.status || seen.read_address !== want.read_address ||
          seen.physical_address !== want.physical_address ||
          seen.page_span !== want.page_span) begin
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("[%0t] mismatch: exp status=%0d rd=%h pa=%h size=%0d",
                     $realtime, want.status, want.read_address, want.physical_address,
                     want.page_span, " / got status=%0d rd=%h pa=%h size=%0d",
                     seen.status, seen.read_address, seen.physical_address,
                     seen.page_span);
      end
   endtask

   // Both channels are sampled at the rising edge, before any update lands.
   always @(posedge clock) begin
      req_payload_type taken;
      rsp_payload_type seen;
      rsp_payload_type guess;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            taken.action     = req_ch.action;
            taken.root_base  = req_ch.root_base;
            taken.virt_addr  = req_ch.virt_addr;
            taken.entry_data = req_ch.entry_data;
            guess = predict_walk(taken);   // always advance the state
            expected_walk_rsps.push_back(cur_is_fixed ? cur_fixed_rsp : guess);
            reqs_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.status           = rsp_ch.status;
            seen.read_address     = rsp_ch.read_address;
            seen.physical_address = rsp_ch.physical_address;
            seen.page_span        = rsp_ch.page_span;
            check_rsp(seen);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random stalls, none in the quiet window, and one long
   // hold-off so the walker backs up and drops req ready.
   // ---------------------------------------------------------------------
   initial begin
      bit held = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && reqs_accepted >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 6);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one transaction and return at the edge that accepts it. Fields the
   // action does not use carry random junk.
   task automatic send_item(logic action, logic [63:0] word, logic [VA_W-1:0] va,
                            bit is_fixed, rsp_payload_type fixed_rsp);
      quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      if (!quiet && $urandom_range(99) < 3) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= action;
      if (action == ACTION_START) begin
         req_ch.root_base  <= word[PA_W-1:0];
         req_ch.virt_addr  <= va;
         req_ch.entry_data <= rand64();
      end else begin
         req_ch.root_base  <= PA_W'(rand64());
         req_ch.virt_addr  <= VA_W'(rand64());
         req_ch.entry_data <= word;
      end
      cur_is_fixed  <= is_fixed;
      cur_fixed_rsp <= fixed_rsp;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Mostly well-formed walks with random entries; some stray responses,
   // starts in mid-walk and not-present entries break them up.
   task automatic run_random_walks();
      logic [63:0] entry;
      logic [1:0]  level;
      bit          walk_over;
      while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(99) < 8)
            send_item(ACTION_RESP, rand64(), '0, 1'b0, '0);
         send_item(ACTION_START, rand64(), VA_W'(rand64()), 1'b0, '0);
         level     = LVL_4;
         walk_over = 1'b0;
         while (!walk_over) begin
            if ($urandom_range(99) < 4)
               send_item(ACTION_START, rand64(), VA_W'(rand64()), 1'b0, '0);
            entry = rand64();
            entry[PTE_PRESENT_BIT] = ($urandom_range(99) >= 8);
            if (level == LVL_3 || level == LVL_2)
               entry[PTE_LARGE_BIT] = ($urandom_range(99) < 25);
            send_item(ACTION_RESP, entry, '0, 1'b0, '0);
            walk_over = !entry[PTE_PRESENT_BIT] || level == LVL_1 ||
                        (entry[PTE_LARGE_BIT] && (level == LVL_3 || level == LVL_2));
            level = level - 2'd1;
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACTION_START;
      req_ch.root_base  <= '0;
      req_ch.virt_addr  <= '0;
      req_ch.entry_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_item(directed_table[i].action, directed_table[i].word, directed_table[i].va,
                   directed_table[i].is_fixed, directed_table[i].fixed_rsp);
      run_random_walks();
      req_ch.valid <= 1'b0;

      while (expected_walk_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      error_count += expected_walk_rsps.size();
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== four_level_page_table_walker.f =====
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_if.sv
hw/rtl/ptw_walk_core.sv
hw/rtl/four_level_page_table_walker.sv
hw/rtl/ptw_checker.sv
bench/testbench.sv
